>>> rtl/line_rasterizer_core_defines.svh
// ----------------------------------------------------------------------------
// line_rasterizer_core_defines
// assertion macros shared by the line rasterizer rtl
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_CORE_DEFINES_SVH
`define LINE_RASTERIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold in the same cycle
`define LR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("line_rasterizer_core: check failed");

// antecedent in one cycle, consequent in the next
`define LR_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("line_rasterizer_core: check failed");

`else

`define LR_ASSERT(label, prop)
`define LR_ASSERT_NEXT(label, pre, post)

`endif

`endif

>>> rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// types and constants shared by the line rasterizer modules
// ----------------------------------------------------------------------------
package lr_pkg;

	localparam int COORD_W     = 6;
	localparam int COLOR_W     = 24;
	localparam int CANVAS_SIZE = 64;
	localparam logic [COORD_W:0] CANVAS_MAX = (COORD_W + 1)'(CANVAS_SIZE - 1);

	// command queue between front and walker
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// classified line command
	typedef struct packed {
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] major_len;
		logic [COORD_W-1:0] minor_len;
		logic               steep;
		logic               y_up;
		logic [COLOR_W-1:0] color;
	} line_cmd_t;

	// walker status seen by the top level
	typedef struct packed {
		logic active;
		logic on_last;
	} walk_status_t;

endpackage

>>> rtl/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// clamps and orders endpoints, derives deltas and octant of a line item
// ----------------------------------------------------------------------------
module lr_front import lr_pkg::*; (
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic [COLOR_W-1:0] line_color,
	output line_cmd_t          cmd
);

	function automatic logic [COORD_W-1:0] clamp(input logic [COORD_W-1:0] v);
		logic [COORD_W:0] w;
		w = {1'b0, v};
		if (w > CANVAS_MAX) begin
			return CANVAS_MAX[COORD_W-1:0];
		end
		return v;
	endfunction

	logic [COORD_W-1:0] ax, ay, bx, by;
	logic [COORD_W-1:0] x0, y0, x1, y1;
	logic [COORD_W-1:0] dx, ady;
	logic               y_up;

	// saturate to canvas
	assign ax = clamp(start_x);
	assign ay = clamp(start_y);
	assign bx = clamp(end_x);
	assign by = clamp(end_y);

	// left endpoint first
	always_comb begin
		if (bx < ax) begin
			x0 = bx; y0 = by; x1 = ax; y1 = ay;
		end else begin
			x0 = ax; y0 = ay; x1 = bx; y1 = by;
		end
	end

	// deltas and direction
	assign dx   = x1 - x0;
	assign y_up = (y1 > y0);
	assign ady  = y_up ? (y1 - y0) : (y0 - y1);

	// classified item
	always_comb begin
		cmd.x0    = x0;
		cmd.y0    = y0;
		cmd.steep = (ady > dx);
		cmd.y_up  = y_up;
		cmd.color = line_color;
		if (ady > dx) begin
			cmd.major_len = ady;
			cmd.minor_len = dx;
		end else begin
			cmd.major_len = dx;
			cmd.minor_len = ady;
		end
	end

endmodule

>>> rtl/lr_queue.sv
// ----------------------------------------------------------------------------
// lr_queue
// small fifo of classified line items between front and walker
// ----------------------------------------------------------------------------
module lr_queue import lr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  line_cmd_t         push_cmd,
	input  logic              pop,
	output line_cmd_t         head,
	output logic              empty,
	output logic              full,
	output logic [QCNT_W-1:0] count
);

	line_cmd_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + QPTR_W'(1);
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign count = count_q;
	assign head  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/lr_walk.sv
// ----------------------------------------------------------------------------
// lr_walk
// bresenham walker, one pixel item per cycle with registered outputs
// ----------------------------------------------------------------------------
module lr_walk import lr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_avail,
	input  line_cmd_t          cmd,
	output logic               cmd_take,
	output walk_status_t       status,
	output logic               pixel_valid,
	output logic [COORD_W-1:0] pixel_x,
	output logic [COORD_W-1:0] pixel_y,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               last_pixel
);

	localparam int ERR_W = COORD_W + 2;
	localparam int SUM_W = ERR_W + 2;

	logic               active_q;
	logic [COORD_W-1:0] x_q, y_q, left_q, major_q, minor_q;
	logic signed [ERR_W-1:0] err_q;
	logic               steep_q, y_up_q;
	logic [COLOR_W-1:0] color_q;

	logic               valid_q, last_q;
	logic [COORD_W-1:0] px_q, py_q;
	logic [COLOR_W-1:0] pcolor_q;

	logic               on_last;
	logic signed [SUM_W-1:0] err_sum, major_s;
	logic               adv;
	logic [ERR_W-1:0]   err_next;
	logic [COORD_W-1:0] y_step, x_next, y_next;

	assign on_last  = (left_q == '0);
	assign cmd_take = cmd_avail && (!active_q || on_last);

	// error update
	assign err_sum  = SUM_W'(err_q) + $signed({{(SUM_W-COORD_W){1'b0}}, minor_q});
	assign major_s  = $signed({{(SUM_W-COORD_W){1'b0}}, major_q});
	assign adv      = ((err_sum <<< 1) >= major_s);
	assign err_next = adv ? ERR_W'(err_sum - major_s) : ERR_W'(err_sum);

	// coordinate update
	assign y_step = y_up_q ? (y_q + COORD_W'(1)) : (y_q - COORD_W'(1));
	always_comb begin
		if (steep_q) begin
			x_next = adv ? (x_q + COORD_W'(1)) : x_q;
			y_next = y_step;
		end else begin
			x_next = x_q + COORD_W'(1);
			y_next = adv ? y_step : y_q;
		end
	end

	// walk payload
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			x_q     <= cmd.x0;
			y_q     <= cmd.y0;
			left_q  <= cmd.major_len;
			major_q <= cmd.major_len;
			minor_q <= cmd.minor_len;
			steep_q <= cmd.steep;
			y_up_q  <= cmd.y_up;
			color_q <= cmd.color;
			err_q   <= '0;
		end else if (active_q && !on_last) begin
			x_q    <= x_next;
			y_q    <= y_next;
			left_q <= left_q - COORD_W'(1);
			err_q  <= $signed(err_next);
		end
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd_take) begin
				active_q <= 1'b1;
			end else if (on_last) begin
				active_q <= 1'b0;
			end
			valid_q <= active_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (active_q) begin
			px_q     <= x_q;
			py_q     <= y_q;
			pcolor_q <= color_q;
			last_q   <= on_last;
		end
	end

	assign pixel_valid    = valid_q;
	assign pixel_x        = px_q;
	assign pixel_y        = py_q;
	assign pixel_color    = pcolor_q;
	assign last_pixel     = last_q;
	assign status.active  = active_q;
	assign status.on_last = on_last;

endmodule

>>> rtl/line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// line_rasterizer_core
// first pixel via queue, walker and output registers, then one pixel a cycle
// a line gives major delta + 1 pixels, at most 64, set by the walker step loop
// a two-item queue takes new lines while the walker runs; busy when it is full
// pixel items are strobed for one cycle and cannot be held off by the receiver
// arst_n clears queue and walker, no item is pending after reset
// ----------------------------------------------------------------------------
`include "line_rasterizer_core_defines.svh"

module line_rasterizer_core import lr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic [COLOR_W-1:0] line_color,
	output logic               pixel_valid,
	output logic [COORD_W-1:0] pixel_x,
	output logic [COORD_W-1:0] pixel_y,
	output logic [COLOR_W-1:0] pixel_color,
	output logic               last_pixel
);

	line_cmd_t         front_cmd, head_cmd;
	logic              q_push, q_pop, q_empty, q_full;
	logic [QCNT_W-1:0] q_count;
	walk_status_t      walk_st;

	// classify incoming item
	lr_front u_front (
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.line_color (line_color),
		.cmd        (front_cmd)
	);

	assign busy   = q_full;
	assign q_push = start && !q_full;

	// decoupling queue
	lr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.empty    (q_empty),
		.full     (q_full),
		.count    (q_count)
	);

	// pixel walker
	lr_walk u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_avail   (!q_empty),
		.cmd         (head_cmd),
		.cmd_take    (q_pop),
		.status      (walk_st),
		.pixel_valid (pixel_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	// checks
	`LR_ASSERT(a_pop_needs_item, !q_pop || !q_empty)
	`LR_ASSERT_NEXT(a_accept_held, q_push, (q_count != '0) || walk_st.active)
	`LR_ASSERT_NEXT(a_walk_strobes, walk_st.active, pixel_valid)
	`LR_ASSERT_NEXT(a_line_ends, walk_st.active && walk_st.on_last && q_empty, pixel_valid && last_pixel)

endmodule
